### design/assert_macros.svh
// Assertion helper macros for the label encoder RTL.
// Checks compile only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### design/dnle_pkg.sv
// Shared types and constants of the DNS name label encoder.
// Used by the control module and the top level.
package dnle_pkg;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DRAIN
  } state_e;

  // Control from the sequencer to the row of storage cells and output mux.
  typedef struct packed {
    logic store;
    logic shift;
    logic emit_len;
  } cell_ctl_t;

endpackage

### design/dnle_cell.sv
// One storage cell of the label buffer row.
// Loads a character when addressed, or takes its neighbor's byte on a shift.
module dnle_cell (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  logic [7:0] char_i,
  input  logic [7:0] next_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = char_i;
    end else if (shift_i) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### design/dnle_ctrl.sv
// Sequencer of the label encoder: label count, overflow flag and beat control.
// Depends on dnle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dnle_ctrl #(
  parameter int unsigned MaxLabel = 63,
  parameter int unsigned CntW     = $clog2(MaxLabel + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        char_in_i,
  input  logic              name_end_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              is_length_o,
  output logic              label_overflow_o,
  output logic              run_last_o,
  output logic [CntW-1:0]   count_o,
  output dnle_pkg::cell_ctl_t ctl_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxLabel);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  dnle_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             in_acc;
  logic             is_dot;
  logic             has_room;

  assign in_acc   = in_valid_i && (state_q == dnle_pkg::ST_IDLE);
  assign is_dot   = (char_in_i == dnle_pkg::DOT_CHAR);
  assign has_room = (count_q < MaxCnt);

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    ovf_d            = ovf_q;
    out_valid_o      = 1'b0;
    is_length_o      = 1'b0;
    label_overflow_o = 1'b0;
    run_last_o       = 1'b0;
    ctl_o            = '0;
    unique case (state_q)
      dnle_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_dot) begin
            state_d = dnle_pkg::ST_LEN;
          end else begin
            // Characters past the label limit are dropped and flagged.
            if (has_room) begin
              ctl_o.store = 1'b1;
              count_d     = count_q + OneCnt;
            end else begin
              ovf_d = 1'b1;
            end
            if (name_end_i) begin
              state_d = dnle_pkg::ST_LEN;
            end
          end
        end
      end
      dnle_pkg::ST_LEN: begin
        out_valid_o      = 1'b1;
        is_length_o      = 1'b1;
        label_overflow_o = ovf_q;
        ctl_o.emit_len   = 1'b1;
        run_last_o       = (count_q == '0);
        if (!out_stall_i) begin
          ovf_d   = 1'b0;
          state_d = (count_q == '0) ? dnle_pkg::ST_IDLE : dnle_pkg::ST_DRAIN;
        end
      end
      dnle_pkg::ST_DRAIN: begin
        // The count now tracks how many characters are still in the row.
        out_valid_o = 1'b1;
        run_last_o  = (count_q == OneCnt);
        if (!out_stall_i) begin
          ctl_o.shift = 1'b1;
          count_d     = count_q - OneCnt;
          if (count_q == OneCnt) begin
            state_d = dnle_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = dnle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dnle_pkg::ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign in_stall_o = (state_q != dnle_pkg::ST_IDLE);
  assign count_o    = count_q;

  `ASSERT_HOLDS(a_count_in_range, clk_i, rst_ni, count_q <= MaxCnt)
  `ASSERT_NEVER(a_store_and_shift, clk_i, rst_ni, ctl_o.store && ctl_o.shift)
  `ASSERT_NEVER(a_drain_empty, clk_i, rst_ni,
                (state_q == dnle_pkg::ST_DRAIN) && (count_q == '0))
  `ASSERT_HOLDS(a_drain_done_idle, clk_i, rst_ni,
                ((state_q == dnle_pkg::ST_DRAIN) && !out_stall_i && (count_q == OneCnt))
                |=> ((state_q == dnle_pkg::ST_IDLE) && (count_q == '0) && !ovf_q))

endmodule

### design/dns_name_label_encoder_core.sv
// DNS name label encoder: dotted name in, length-prefixed label bytes out.
// A character that is neither a dot nor the last of the name is taken and yields no beat.
// A flushing item (dot or last character) gives the length beat in the cycle after it is
// taken and then one character beat per cycle while the receiver does not stall; input is
// stalled until the last beat of the run is taken.
// Reset clears the sequencer, the label count and the overflow flag; the cells do not reset.
module dns_name_label_encoder_core #(
  parameter int unsigned MAX_LABEL = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       name_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       is_length_o,
  output logic       label_overflow_o,
  output logic       run_last_o
);

  localparam int unsigned CntW = $clog2(MAX_LABEL + 1);

  logic [CntW-1:0]     count;
  dnle_pkg::cell_ctl_t ctl;
  logic [7:0]          cell_data [MAX_LABEL];

  dnle_ctrl #(
    .MaxLabel (MAX_LABEL),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .char_in_i        (char_in_i),
    .name_end_i       (name_end_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_length_o      (is_length_o),
    .label_overflow_o (label_overflow_o),
    .run_last_o       (run_last_o),
    .count_o          (count),
    .ctl_o            (ctl)
  );

  // Cell k takes the character when the count points at it; on a shift the
  // row moves one place toward cell 0, which feeds the output.
  for (genvar k = 0; k < MAX_LABEL; k++) begin : g_cell
    logic [7:0] next_data;
    logic       load;

    if (k == MAX_LABEL - 1) begin : g_tail
      assign next_data = 8'h00;
    end else begin : g_body
      assign next_data = cell_data[k+1];
    end

    assign load = ctl.store && (count == CntW'(k));

    dnle_cell u_cell (
      .clk_i   (clk_i),
      .load_i  (load),
      .shift_i (ctl.shift),
      .char_i  (char_in_i),
      .next_i  (next_data),
      .data_o  (cell_data[k])
    );
  end

  assign byte_out_o = ctl.emit_len ? 8'(count) : cell_data[0];

endmodule

### tb/sv/label_beat_checker.sv
// Checker for the DNS name label encoder: watches both channels, predicts the
// label beats from each accepted character and compares them with the output.
// Depends on dnle_pkg for the dot character.
module label_beat_checker #(
  parameter int unsigned MAX_LABEL = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] char_in_i,
  input  logic       name_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] byte_out_i,
  input  logic       is_length_i,
  input  logic       label_overflow_i,
  input  logic       run_last_i,
  output int         pending_o,
  output int         mismatch_count_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_len;
    logic       ovf;
    logic       last;
  } label_beat_t;

  label_beat_t expected_beats[$];
  logic [7:0]  label_chars [0:MAX_LABEL-1];
  logic [5:0]  label_len;
  logic        chars_dropped;
  int          beat_num;
  int          mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // Queues the length beat and then every stored character of the label.
  task automatic flush_label();
    label_beat_t b;
    int i;
    b.data   = {2'b00, label_len};
    b.is_len = 1'b1;
    b.ovf    = chars_dropped;
    b.last   = (label_len == 6'd0);
    expected_beats.push_back(b);
    for (i = 0; i < int'(label_len); i++) begin
      b.data   = label_chars[i];
      b.is_len = 1'b0;
      b.ovf    = 1'b0;
      b.last   = (i == int'(label_len) - 1);
      expected_beats.push_back(b);
    end
    label_len     = '0;
    chars_dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : label_model
    label_beat_t want;
    if (!rst_ni) begin
      expected_beats.delete();
      label_len     = '0;
      chars_dropped = 1'b0;
      beat_num      = 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat %0d: unexpected byte 'h%02h", beat_num, byte_out_i));
        end else begin
          want = expected_beats.pop_front();
          if (byte_out_i !== want.data)
            report_mismatch($sformatf("beat %0d: byte_out 'h%02h, expected 'h%02h",
                                      beat_num, byte_out_i, want.data));
          if (is_length_i !== want.is_len)
            report_mismatch($sformatf("beat %0d: is_length %b, expected %b",
                                      beat_num, is_length_i, want.is_len));
          if (label_overflow_i !== want.ovf)
            report_mismatch($sformatf("beat %0d: label_overflow %b, expected %b",
                                      beat_num, label_overflow_i, want.ovf));
          if (run_last_i !== want.last)
            report_mismatch($sformatf("beat %0d: run_last %b, expected %b",
                                      beat_num, run_last_i, want.last));
        end
        beat_num++;
      end
      if (in_valid_i && !in_stall_i) begin
        if (char_in_i == dnle_pkg::DOT_CHAR) begin
          flush_label();
        end else begin
          // A full label keeps its characters and only remembers the overflow.
          if (label_len < MAX_LABEL) begin
            label_chars[label_len] = char_in_i;
            label_len++;
          end else begin
            chars_dropped = 1'b1;
          end
          if (name_end_i) flush_label();
        end
      end
      pending_o <= expected_beats.size();
    end
  end

endmodule

### tb/sv/tb.sv
// Top of the label encoder testbench: clock, reset, character stimulus,
// receiver stalls, watchdog and verdict. Depends on dnle_pkg, the encoder
// core and label_beat_checker.
module tb;

  localparam int unsigned MAX_LABEL = 63;
  localparam int TOTAL_ITEMS  = 430;
  localparam int QUIET_AFTER  = 370;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_in_i;
  logic       name_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] byte_out_o;
  logic       is_length_o;
  logic       label_overflow_o;
  logic       run_last_o;

  int   pending;
  int   mismatch_count;
  int   items_sent;
  logic quiet;
  logic gaps_on;

  dns_name_label_encoder_core #(
    .MAX_LABEL(MAX_LABEL)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_in_i       (char_in_i),
    .name_end_i      (name_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_out_o      (byte_out_o),
    .is_length_o     (is_length_o),
    .label_overflow_o(label_overflow_o),
    .run_last_o      (run_last_o)
  );

  label_beat_checker #(
    .MAX_LABEL(MAX_LABEL)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .char_in_i       (char_in_i),
    .name_end_i      (name_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_out_i      (byte_out_o),
    .is_length_i     (is_length_o),
    .label_overflow_i(label_overflow_o),
    .run_last_i      (run_last_o),
    .pending_o       (pending),
    .mismatch_count_o(mismatch_count)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] pick_label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == dnle_pkg::DOT_CHAR) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Mostly short labels, with a few that fill or overrun the label buffer.
  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 90) return $urandom_range(1, 12);
    if (r < 94) return MAX_LABEL;
    if (r < 97) return MAX_LABEL + 1;
    return $urandom_range(MAX_LABEL + 2, MAX_LABEL + 7);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    name_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_label(input int len, input logic end_on_last);
    int i;
    for (i = 0; i < len; i++) send_char(pick_label_char(), end_on_last && (i == len - 1));
  endtask

  // A well-formed name ends either on its last character or on a final dot.
  task automatic send_name();
    int   labels;
    int   len;
    int   i;
    logic end_on_char;
    labels  = $urandom_range(1, 4);
    gaps_on = ($urandom_range(0, 2) != 0);
    for (i = 0; i < labels; i++) begin
      len = pick_label_len();
      end_on_char = (i == labels - 1) && (len > 0) && ($urandom_range(0, 2) != 0);
      send_label(len, end_on_char);
      if (i < labels - 1) send_char(dnle_pkg::DOT_CHAR, 1'b0);
      else if (!end_on_char) send_char(dnle_pkg::DOT_CHAR, 1'b1);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_char(($urandom_range(0, 2) == 0) ? dnle_pkg::DOT_CHAR : 8'($urandom_range(0, 255)),
                $urandom_range(0, 3) == 0);
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_valid_i = 1'b0;
    char_in_i  = 8'h00;
    name_end_i = 1'b0;
    rst_ni     = 1'b0;
    quiet      = 1'b0;
    gaps_on    = 1'b1;
    items_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two plain labels, the second ended on its character.
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char("c", 1'b1);
    // A leading dot and then two dots in a row give empty labels.
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char("x", 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    // A name that is only a final dot.
    send_char(dnle_pkg::DOT_CHAR, 1'b1);
    // The zero character is stored like any other.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    // A final dot after a label flushes it once.
    send_char("q", 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b1);
    send_char(8'h2D, 1'b0);
    send_char(8'h2F, 1'b0);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b1);
    drain_pending();

    // One label that exactly fills the buffer, then one that overruns it and
    // ends on a dropped character.
    send_label(MAX_LABEL, 1'b0);
    send_char(dnle_pkg::DOT_CHAR, 1'b0);
    send_label(MAX_LABEL + 3, 1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      quiet = (items_sent >= QUIET_AFTER);
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_name();
      if (!quiet && $urandom_range(0, 11) == 0) drain_pending();
    end
    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : receiver_stalls
    out_stall_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (!rst_ni) @(posedge clk_i);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
